>>> rtl/core/i2cms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_pkg: I2C master transfer sequencer package
// Shared widths, codes and the transmit store write bundle.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LPOS_W      = 4;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic READ_BIT = 1'b1;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_EVENT = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_START      = 4'd0,
    ST_REPSTART   = 4'd1,
    ST_SLAW_ACK   = 4'd2,
    ST_SLAW_NACK  = 4'd3,
    ST_DATA_ACK   = 4'd4,
    ST_DATA_NACK  = 4'd5,
    ST_SLAR_ACK   = 4'd6,
    ST_SLAR_NACK  = 4'd7,
    ST_RX_ACK     = 4'd8,
    ST_RX_NACK    = 4'd9,
    ST_ARB_LOST   = 4'd10,
    ST_ILLEGAL    = 4'd11,
    ST_NONE       = 4'd12
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_RX_ACK  = 3'd4,
    CMD_RX_NACK = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_BUSY      = 3'd1,
    ERR_SLAW_NACK = 3'd2,
    ERR_DATA_NACK = 3'd3,
    ERR_SLAR_NACK = 3'd4,
    ERR_ARB       = 3'd5,
    ERR_ILLEGAL   = 3'd6
  } err_e;

  typedef struct packed {
    logic              we;
    logic [LPOS_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

endpackage : i2cms_pkg
`default_nettype wire

>>> rtl/core/i2cms_tx_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_tx_store: transmit byte store
// One write port, one registered read at the next send position (write
// forwarded), plus a copy of entry zero for sends right at transfer start.
// ----------------------------------------------------------------------------
module i2cms_tx_store
  import i2cms_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire store_wr_t                    wr_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]   raddr_i,
  output logic      [BYTE_W-1:0]            rdata_o,
  output logic      [BYTE_W-1:0]            head_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_q;
  logic [BYTE_W-1:0] head_q;
  logic [IDX_W-1:0]  widx;
  logic [IDX_W-1:0]  ridx;

  assign widx = IDX_W'(wr_i.addr);
  assign ridx = raddr_i[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[widx] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we && (widx == ridx)) begin
      rd_q <= wr_i.data;
    end else begin
      rd_q <= mem[ridx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we && (wr_i.addr == '0)) begin
      head_q <= wr_i.data;
    end
  end

  assign rdata_o = rd_q;
  assign head_o  = head_q;

endmodule : i2cms_tx_store
`default_nettype wire

>>> rtl/core/i2c_master_transfer_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer: I2C master transfer sequencer
// Path: an accepted input word waits in the input register, then one decision
// step writes the result register. Throughput: one word per cycle unless
// the result side stalls; the step is a single pass over the state.
// Reset: control state, mode and error clear at once; store contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer
  import i2cms_pkg::*;
#(
  parameter int unsigned TX_DEPTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // lsb up: load_position, load_byte, count, hold_bus, target_addr, bus_status, rx_byte
  input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
  // lsb up: func
  input  wire logic [IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // lsb up: accepted, bus_command, tx_out, rx_valid, rx_out, rx_position,
  // error_code, is_ready, zero pad
  output logic      [OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned LEN_W = $clog2(TX_DEPTH + 1);

  localparam logic [2:0] MODE_READY    = 3'd0;
  localparam logic [2:0] MODE_INIT     = 3'd1;
  localparam logic [2:0] MODE_REPSTART = 3'd2;
  localparam logic [2:0] MODE_MT       = 3'd3;
  localparam logic [2:0] MODE_MR       = 3'd4;

  // input register
  logic                  in_vld_q;
  logic [IN_TDATA_W-1:0] in_data_q;
  func_e                 in_func_q;
  logic                  fire;

  // fields
  logic [LPOS_W-1:0] f_lpos;
  logic [BYTE_W-1:0] f_lbyte;
  logic [7:0]        f_cnt;
  logic              f_hold;
  logic [6:0]        f_addr;
  status_e           f_status;
  logic [BYTE_W-1:0] f_rxb;

  // state
  logic [2:0]        mode_q, mode_d;
  err_e              err_q, err_d;
  logic              keep_q, keep_d;
  logic [LEN_W-1:0]  tx_len_q, tx_len_d;
  logic [LEN_W-1:0]  tx_pos_q, tx_pos_d;
  logic [7:0]        rx_len_q, rx_len_d;
  logic [7:0]        rx_cnt_q, rx_cnt_d;
  logic [BYTE_W-1:0] addr_byte_q, addr_byte_d;
  logic              reading_q, reading_d;

  // store
  store_wr_t         st_wr;
  logic [BYTE_W-1:0] st_rdata;
  logic [BYTE_W-1:0] st_head;
  logic [BYTE_W-1:0] send_byte;

  // step result
  logic              r_acc;
  cmd_e              r_cmd;
  logic [BYTE_W-1:0] r_txo;
  logic              r_rxv;
  logic [BYTE_W-1:0] r_rxo;
  logic [7:0]        r_rxp;
  logic [7:0]        rx_cnt_inc;

  // result register
  logic                   out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  function automatic cmd_e rx_cmd(input logic [7:0] cnt, input logic [7:0] len);
    cmd_e c;
    c = (({1'b0, cnt} + 9'd1) < {1'b0, len}) ? CMD_RX_ACK : CMD_RX_NACK;
    return c;
  endfunction

  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;

  assign f_lpos   = in_data_q[3:0];
  assign f_lbyte  = in_data_q[11:4];
  assign f_cnt    = in_data_q[19:12];
  assign f_hold   = in_data_q[20];
  assign f_addr   = in_data_q[27:21];
  assign f_status = status_e'(in_data_q[31:28]);
  assign f_rxb    = in_data_q[39:32];

  assign rx_cnt_inc = rx_cnt_q + 8'd1;
  assign send_byte  = reading_q ? addr_byte_q :
                      ((tx_pos_q < LEN_W'(TX_DEPTH)) ? st_rdata : '0);

  always_comb begin
    mode_d      = mode_q;
    err_d       = err_q;
    keep_d      = keep_q;
    tx_len_d    = tx_len_q;
    tx_pos_d    = tx_pos_q;
    rx_len_d    = rx_len_q;
    rx_cnt_d    = rx_cnt_q;
    addr_byte_d = addr_byte_q;
    reading_d   = reading_q;
    st_wr.we    = 1'b0;
    st_wr.addr  = f_lpos;
    st_wr.data  = f_lbyte;
    r_acc       = 1'b0;
    r_cmd       = CMD_NONE;
    r_txo       = '0;
    r_rxv       = 1'b0;
    r_rxo       = '0;
    r_rxp       = '0;
    if (fire) begin
      case (in_func_q)
        FUNC_LOAD: begin
          st_wr.we = ({5'd0, f_lpos} < 9'(TX_DEPTH));
        end
        FUNC_WRITE, FUNC_READ: begin
          if (mode_q inside {MODE_READY, MODE_REPSTART}) begin
            r_acc    = 1'b1;
            keep_d   = f_hold;
            tx_pos_d = '0;
            if (in_func_q == FUNC_WRITE) begin
              reading_d = 1'b0;
              tx_len_d  = ({1'b0, f_cnt} > 9'(TX_DEPTH)) ? LEN_W'(TX_DEPTH) : LEN_W'(f_cnt);
            end else begin
              reading_d   = 1'b1;
              addr_byte_d = {f_addr, READ_BIT};
              rx_len_d    = f_cnt;
              rx_cnt_d    = '0;
              tx_len_d    = LEN_W'(1);
            end
            err_d  = ERR_BUSY;
            mode_d = MODE_INIT;
            if (mode_q == MODE_REPSTART) begin
              r_txo    = reading_d ? addr_byte_d : st_head;
              tx_pos_d = LEN_W'(1);
              r_cmd    = CMD_SEND;
            end else begin
              r_cmd = CMD_START;
            end
          end
        end
        default: begin
          case (f_status)
            ST_START, ST_SLAW_ACK, ST_DATA_ACK: begin
              if (f_status == ST_SLAW_ACK) begin
                mode_d = MODE_MT;
              end
              if (tx_pos_q < tx_len_q) begin
                r_txo    = send_byte;
                tx_pos_d = tx_pos_q + LEN_W'(1);
                err_d    = ERR_BUSY;
                r_cmd    = CMD_SEND;
              end else begin
                err_d = ERR_OK;
                if (keep_q) begin
                  r_cmd = CMD_START;
                end else begin
                  mode_d = MODE_READY;
                  r_cmd  = CMD_STOP;
                end
              end
            end
            ST_SLAR_ACK: begin
              mode_d = MODE_MR;
              err_d  = ERR_BUSY;
              r_cmd  = rx_cmd(rx_cnt_q, rx_len_q);
            end
            ST_RX_ACK: begin
              r_rxv    = 1'b1;
              r_rxo    = f_rxb;
              r_rxp    = rx_cnt_q;
              rx_cnt_d = rx_cnt_inc;
              err_d    = ERR_BUSY;
              r_cmd    = rx_cmd(rx_cnt_inc, rx_len_q);
            end
            ST_RX_NACK, ST_SLAW_NACK, ST_DATA_NACK, ST_SLAR_NACK, ST_ARB_LOST: begin
              case (f_status)
                ST_RX_NACK: begin
                  r_rxv    = 1'b1;
                  r_rxo    = f_rxb;
                  r_rxp    = rx_cnt_q;
                  rx_cnt_d = rx_cnt_inc;
                  err_d    = ERR_OK;
                end
                ST_SLAW_NACK: err_d = ERR_SLAW_NACK;
                ST_DATA_NACK: err_d = ERR_DATA_NACK;
                ST_SLAR_NACK: err_d = ERR_SLAR_NACK;
                default:      err_d = ERR_ARB;
              endcase
              if (keep_q) begin
                r_cmd = CMD_START;
              end else begin
                mode_d = MODE_READY;
                r_cmd  = CMD_STOP;
              end
            end
            ST_REPSTART: begin
              mode_d = MODE_REPSTART;
            end
            ST_ILLEGAL: begin
              err_d  = ERR_ILLEGAL;
              mode_d = MODE_READY;
              r_cmd  = CMD_STOP;
            end
            default: begin
            end
          endcase
        end
      endcase
    end
  end

  i2cms_tx_store #(
    .DEPTH (TX_DEPTH)
  ) u_tx_store (
    .clk_i   (clk_i),
    .wr_i    (st_wr),
    .raddr_i (tx_pos_d),
    .rdata_o (st_rdata),
    .head_o  (st_head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      mode_q      <= MODE_READY;
      err_q       <= ERR_OK;
      keep_q      <= 1'b0;
      tx_len_q    <= '0;
      tx_pos_q    <= '0;
      rx_len_q    <= '0;
      rx_cnt_q    <= '0;
      addr_byte_q <= '0;
      reading_q   <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      mode_q      <= mode_d;
      err_q       <= err_d;
      keep_q      <= keep_d;
      tx_len_q    <= tx_len_d;
      tx_pos_q    <= tx_pos_d;
      rx_len_q    <= rx_len_d;
      rx_cnt_q    <= rx_cnt_d;
      addr_byte_q <= addr_byte_d;
      reading_q   <= reading_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_func_q <= func_e'(s_axis_tuser);
    end
    if (fire) begin
      out_data_q <= {7'd0,
                     (mode_d == MODE_READY) || (mode_d == MODE_REPSTART),
                     err_d, r_rxp, r_rxo, r_rxv, r_txo, r_cmd, r_acc};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule : i2c_master_transfer_sequencer
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: I2C master transfer sequencer testbench
// Feeds store loads, transfer starts and bus status words into the sequencer,
// tracks the sequencer state in a behavioral copy to predict each bus
// decision, and checks the result words in order under random stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cms_pkg::*;

  localparam int unsigned TX_DEPTH = 16;
  localparam int unsigned N_WORDS  = 1350;
  localparam logic [3:0]  ST_UNUSED = 4'hF;

  typedef enum logic [2:0] {
    M_READY,
    M_INIT,
    M_REPSTART,
    M_MT,
    M_MR
  } bus_mode_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [3:0] bus_status;
    logic [6:0] target_addr;
    logic       hold_bus;
    logic [7:0] count;
    logic [7:0] load_byte;
    logic [3:0] load_position;
  } host_word_t;

  typedef struct packed {
    logic [6:0] pad;
    logic       is_ready;
    logic [2:0] error_code;
    logic [7:0] rx_position;
    logic [7:0] rx_out;
    logic       rx_valid;
    logic [7:0] tx_out;
    logic [2:0] bus_command;
    logic       accepted;
  } decision_t;

  typedef struct {
    func_e      func;
    host_word_t word;
    bit         drain;
  } queued_word_t;

  logic                   clk_i;
  logic                   rst_ni   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  host_word_t             s_tdata  = '0;
  func_e                  s_tuser  = FUNC_LOAD;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  queued_word_t host_words[$];
  decision_t    predicted_decisions[$];
  int unsigned  n_words     = 0;
  int unsigned  words_sent  = 0;
  int unsigned  phase_len   = 0;
  int unsigned  send_idle   = 20;
  int unsigned  recv_idle   = 80;
  int unsigned  mismatches  = 0;
  bit           held_gen    = 1'b0;

  // shadow of the sequencer state
  bus_mode_e   mode_q      = M_READY;
  err_e        last_err_q  = ERR_OK;
  logic        keep_bus_q  = 1'b0;
  logic [7:0]  tx_bytes_q[TX_DEPTH];
  int unsigned tx_len_q    = 0;
  int unsigned tx_pos_q    = 0;
  logic [7:0]  rx_len_q    = '0;
  logic [7:0]  rx_cnt_q    = '0;
  logic [7:0]  addr_byte_q = '0;
  logic        reading_q   = 1'b0;

  i2c_master_transfer_sequencer #(
    .TX_DEPTH(TX_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic bus_ready();
    return mode_q == M_READY || mode_q == M_REPSTART;
  endfunction

  function automatic logic [7:0] next_tx_byte();
    logic [7:0] b;
    b = 8'h00;
    if (reading_q) b = addr_byte_q;
    else if (tx_pos_q < TX_DEPTH) b = tx_bytes_q[tx_pos_q];
    tx_pos_q = (tx_pos_q + 1) & 32'h1FF;
    return b;
  endfunction

  function automatic cmd_e finish_xfer(err_e err);
    last_err_q = err;
    if (keep_bus_q) return CMD_START;
    mode_q = M_READY;
    return CMD_STOP;
  endfunction

  function automatic cmd_e rx_request();
    last_err_q = ERR_BUSY;
    return (int'(rx_cnt_q) + 1 < int'(rx_len_q)) ? CMD_RX_ACK : CMD_RX_NACK;
  endfunction

  function automatic decision_t decide_bus_action(func_e fn, host_word_t w);
    decision_t d;
    d = '0;
    case (fn)
      FUNC_LOAD: tx_bytes_q[w.load_position] = w.load_byte;
      FUNC_WRITE, FUNC_READ: begin
        // refused start leaves everything alone
        if (bus_ready()) begin
          d.accepted = 1'b1;
          keep_bus_q = w.hold_bus;
          tx_pos_q = 0;
          if (fn == FUNC_WRITE) begin
            reading_q = 1'b0;
            tx_len_q = (w.count > TX_DEPTH) ? TX_DEPTH : w.count;
          end else begin
            reading_q = 1'b1;
            addr_byte_q = {w.target_addr, READ_BIT};
            rx_len_q = w.count;
            rx_cnt_q = 8'd0;
            tx_len_q = 1;
          end
          last_err_q = ERR_BUSY;
          // after a repeated start the first byte goes out at once
          if (mode_q == M_REPSTART) begin
            d.tx_out = next_tx_byte();
            d.bus_command = CMD_SEND;
          end else begin
            d.bus_command = CMD_START;
          end
          mode_q = M_INIT;
        end
      end
      FUNC_EVENT: begin
        case (w.bus_status)
          ST_START, ST_SLAW_ACK, ST_DATA_ACK: begin
            if (w.bus_status == ST_SLAW_ACK) mode_q = M_MT;
            if (tx_pos_q < tx_len_q) begin
              d.tx_out = next_tx_byte();
              last_err_q = ERR_BUSY;
              d.bus_command = CMD_SEND;
            end else begin
              d.bus_command = finish_xfer(ERR_OK);
            end
          end
          ST_SLAR_ACK: begin
            mode_q = M_MR;
            d.bus_command = rx_request();
          end
          ST_RX_ACK, ST_RX_NACK: begin
            d.rx_valid = 1'b1;
            d.rx_out = w.rx_byte;
            d.rx_position = rx_cnt_q;
            rx_cnt_q = rx_cnt_q + 8'd1;
            if (w.bus_status == ST_RX_ACK) d.bus_command = rx_request();
            else d.bus_command = finish_xfer(ERR_OK);
          end
          ST_SLAW_NACK: d.bus_command = finish_xfer(ERR_SLAW_NACK);
          ST_DATA_NACK: d.bus_command = finish_xfer(ERR_DATA_NACK);
          ST_SLAR_NACK: d.bus_command = finish_xfer(ERR_SLAR_NACK);
          ST_ARB_LOST:  d.bus_command = finish_xfer(ERR_ARB);
          ST_REPSTART:  mode_q = M_REPSTART;
          ST_ILLEGAL: begin
            last_err_q = ERR_ILLEGAL;
            mode_q = M_READY;
            d.bus_command = CMD_STOP;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    d.error_code = last_err_q;
    d.is_ready = bus_ready();
    return d;
  endfunction

  // ---- stimulus builders ----
  function automatic host_word_t rnd_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[39:0];
  endfunction

  task automatic add_word(func_e f, host_word_t w);
    host_words.push_back('{func: f, word: w, drain: 1'b0});
    n_words++;
  endtask

  task automatic mark_drain();
    host_words.push_back('{func: FUNC_LOAD, word: '0, drain: 1'b1});
  endtask

  task automatic bus_event(logic [3:0] s);
    host_word_t w;
    w = rnd_word();
    w.bus_status = s;
    add_word(FUNC_EVENT, w);
  endtask

  task automatic host_start(func_e f, logic [7:0] n, logic hold, logic [6:0] addr);
    host_word_t w;
    w = rnd_word();
    w.count = n;
    w.hold_bus = hold;
    w.target_addr = addr;
    add_word(f, w);
  endtask

  // one write or read transfer; faults only when no extra receives are asked
  task automatic run_xfer(func_e f, int unsigned n, int unsigned extra);
    int unsigned steps;
    logic        hold;
    bit          skip_start;
    bit          aborted;
    bit          broken;
    hold = 1'($urandom_range(1));
    aborted = 1'b0;
    broken = 1'b0;
    host_start(f, n[7:0], hold, 7'($urandom_range(127)));
    skip_start = held_gen && ($urandom_range(9) != 0);
    if (!skip_start) bus_event(ST_START);
    if (f == FUNC_WRITE) begin
      steps = (n > TX_DEPTH) ? TX_DEPTH : n;
      if (steps == 0 && skip_start) steps = 1;
      for (int unsigned i = 0; i < steps && !aborted; i++) begin
        if (extra == 0 && $urandom_range(49) == 0) begin
          aborted = 1'b1;
          broken = 1'b1;
        end else if (extra == 0 && $urandom_range(24) == 0) begin
          if (i == 0) bus_event(ST_SLAW_NACK);
          else if ($urandom_range(1)) bus_event(ST_DATA_NACK);
          else bus_event(ST_ARB_LOST);
          aborted = 1'b1;
        end else begin
          bus_event((i == 0) ? ST_SLAW_ACK : ST_DATA_ACK);
        end
      end
    end else begin
      if (extra == 0 && $urandom_range(19) == 0) begin
        bus_event(ST_SLAR_NACK);
        aborted = 1'b1;
      end else begin
        bus_event(ST_SLAR_ACK);
      end
      steps = ((n == 0) ? 1 : n) + extra;
      for (int unsigned i = 0; i < steps && !aborted; i++) begin
        if (extra == 0 && $urandom_range(59) == 0) begin
          aborted = 1'b1;
          broken = 1'b1;
        end else if (extra == 0 && $urandom_range(39) == 0) begin
          bus_event(ST_ARB_LOST);
          aborted = 1'b1;
        end else begin
          bus_event((i == steps - 1) ? ST_RX_NACK : ST_RX_ACK);
        end
      end
    end
    if (broken) begin
      held_gen = 1'b0;
      if ($urandom_range(1)) bus_event(ST_ILLEGAL);
    end else if (hold) begin
      if ($urandom_range(9) != 0) begin
        bus_event(ST_REPSTART);
        held_gen = 1'b1;
      end else begin
        bus_event(ST_ILLEGAL);
        held_gen = 1'b0;
      end
    end else begin
      held_gen = 1'b0;
    end
  endtask

  function automatic string show(decision_t d);
    return $sformatf("acc=%0d cmd=%0d tx=%h rxv=%0d rx=%h pos=%0d err=%0d rdy=%0d",
                     d.accepted, d.bus_command, d.tx_out, d.rx_valid, d.rx_out,
                     d.rx_position, d.error_code, d.is_ready);
  endfunction

  task automatic flag_mismatch(string what, decision_t want, decision_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: want %s | got %s", $time, what, show(want), show(got));
  endtask

  // ---- driver ----
  always @(posedge clk_i) begin
    queued_word_t nxt;
    if (rst_ni) begin
      if (s_tvalid && s_tready)
        predicted_decisions.push_back(decide_bus_action(s_tuser, s_tdata));
      if (!s_tvalid || s_tready) begin
        if (host_words.size() != 0 && host_words[0].drain) begin
          if (predicted_decisions.size() == 0) void'(host_words.pop_front());
          s_tvalid <= 1'b0;
        end else if (host_words.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = host_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.word;
          s_tuser  <= nxt.func;
          words_sent++;
          if (words_sent == phase_len) begin
            send_idle = 80;
            recv_idle = 20;
          end else if (words_sent == 2 * phase_len) begin
            send_idle = 0;
            recv_idle = 0;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk_i) begin
    decision_t got;
    decision_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (predicted_decisions.size() == 0) begin
          flag_mismatch("word with nothing pending", '0, got);
        end else begin
          want = predicted_decisions.pop_front();
          if (got.accepted !== want.accepted || got.bus_command !== want.bus_command ||
              got.tx_out !== want.tx_out || got.rx_valid !== want.rx_valid ||
              got.rx_out !== want.rx_out || got.rx_position !== want.rx_position ||
              got.error_code !== want.error_code || got.is_ready !== want.is_ready)
            flag_mismatch("bad result word", want, got);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    host_word_t  w;
    int unsigned pick;
    int unsigned n;
    int unsigned next_drain;
    func_e       f;
    bit          wrapped;

    // fill the whole store first so no unwritten entry is ever sent
    for (int i = 0; i < TX_DEPTH; i++) begin
      w = rnd_word();
      w.load_position = i[3:0];
      if (i == 0) w.load_byte = 8'h00;
      else if (i == TX_DEPTH - 1) w.load_byte = 8'hFF;
      add_word(FUNC_LOAD, w);
    end
    host_start(FUNC_WRITE, 8'hFF, 1'b1, 7'h00);   // saturating length
    host_start(FUNC_READ, 8'h05, 1'b0, 7'h55);    // refused, busy
    bus_event(ST_ARB_LOST);                       // held bus -> start
    bus_event(ST_REPSTART);
    host_start(FUNC_WRITE, 8'h00, 1'b0, 7'h2A);   // zero length after repstart
    bus_event(ST_DATA_ACK);
    host_start(FUNC_READ, 8'h00, 1'b0, 7'h7F);    // zero-length read
    bus_event(ST_START);
    bus_event(ST_SLAR_ACK);
    bus_event(ST_RX_NACK);
    bus_event(ST_NONE);
    bus_event(ST_UNUSED);
    bus_event(ST_ILLEGAL);
    mark_drain();

    next_drain = n_words + 400;
    wrapped = 1'b0;
    while (n_words < N_WORDS) begin
      if (n_words >= next_drain) begin
        mark_drain();
        next_drain += 400;
      end
      pick = $urandom_range(99);
      if (!wrapped && n_words >= N_WORDS / 2) begin
        // long read that runs the receive counter past 255
        bus_event(ST_ILLEGAL);
        held_gen = 1'b0;
        run_xfer(FUNC_READ, 255, 3);
        wrapped = 1'b1;
      end else if (pick < 10) begin
        repeat ($urandom_range(3, 1)) begin
          w = rnd_word();
          f = func_e'($urandom_range(3));
          add_word(f, w);
        end
        held_gen = 1'b0;
      end else if (pick < 20) begin
        repeat ($urandom_range(4, 1)) add_word(FUNC_LOAD, rnd_word());
      end else begin
        f = (pick < 60) ? FUNC_WRITE : FUNC_READ;
        if ($urandom_range(24) == 0) n = $urandom_range(255, 17);
        else n = $urandom_range((f == FUNC_WRITE) ? TX_DEPTH : 8, 0);
        run_xfer(f, n, 0);
      end
    end
    phase_len = n_words / 3;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (host_words.size() != 0 || s_tvalid || predicted_decisions.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("i2c_master_transfer_sequencer: match");
    end else begin
      $display("i2c_master_transfer_sequencer: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("i2c_master_transfer_sequencer: mismatch");
    $finish;
  end

endmodule
